// ----- rtl/core/eust_pkg.sv -----
// Shared types and constants for the summer time converter.
`timescale 1ns / 1ps

package eust_pkg;

	localparam int unsigned TimeW   = 32;
	localparam int unsigned OffW    = 17;
	localparam int unsigned LocalW  = 34;
	localparam int unsigned YearW   = 12;
	localparam int unsigned MonthW  = 4;
	localparam int unsigned DayW    = 5;
	localparam int unsigned DaysW   = 16;
	localparam int unsigned DoeW    = 18;
	localparam int unsigned YoeW    = 9;
	localparam int unsigned DoyW    = 9;
	localparam int unsigned WdayW   = 3;

	// configuration register indexes
	localparam logic CFG_WINTER = 1'b0;
	localparam logic CFG_SUMMER = 1'b1;

	localparam logic [OffW-1:0] WINTER_RESET = 17'd3600;
	localparam logic [OffW-1:0] SUMMER_RESET = 17'd7200;

	// floor(x/d) = (x*ceil(2^k/d)) >> k, exact over the ranges used
	localparam int unsigned DAY_K = 35;          // (t>>7)/675, t>>7 < 2^25
	localparam logic [25:0] DAY_RECIP = 26'(((64'd1 << DAY_K) + 64'd674) / 64'd675);
	localparam int unsigned W7_K = 19;           // x/7, x < 2^16
	localparam logic [16:0] W7_RECIP = 17'(((64'd1 << W7_K) + 64'd6) / 64'd7);
	localparam int unsigned Q1460_K = 29;        // doe/1460
	localparam logic [18:0] Q1460_RECIP = 19'(((64'd1 << Q1460_K) + 64'd1459) / 64'd1460);
	localparam int unsigned Q365_K = 28;         // numer/365
	localparam logic [19:0] Q365_RECIP = 20'(((64'd1 << Q365_K) + 64'd364) / 64'd365);
	localparam int unsigned Q153_K = 19;         // (5*doy+2)/153
	localparam logic [11:0] Q153_RECIP = 12'(((64'd1 << Q153_K) + 64'd152) / 64'd153);

	localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
	localparam logic [19:0] ERA5_START  = 20'd730485;
	localparam logic [19:0] ERA4_START  = 20'd584388;

	typedef struct packed {
		logic [TimeW-1:0]  t;
		logic [YearW-1:0]  year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0]   day;
		logic [WdayW-1:0]  wday;   // weekday of the date, 0 is Sunday
	} civil_t;

	// first day of month mp in a March-based year: (153*mp+2)/5
	function automatic logic [DoyW-1:0] month_start(input logic [3:0] mp);
		logic [DoyW-1:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/eust_date.sv -----
// Seven-stage pipeline from Unix seconds to Gregorian date and weekday.
`timescale 1ns / 1ps

module eust_date (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [eust_pkg::TimeW-1:0]      unix_seconds,
	output logic                            out_valid,
	output eust_pkg::civil_t                civil
);

	logic [6:0] valid_s;

	// stage 1: day number
	logic [50:0] day_prod;
	logic [eust_pkg::DaysW-1:0] days_s1;
	logic [eust_pkg::TimeW-1:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;

	// stage 2: era, day of era, weekday
	logic [19:0] z;
	logic        era5_c;
	logic [eust_pkg::DaysW-1:0] wx;
	logic [32:0] wprod;
	logic [13:0] wq;
	logic [eust_pkg::DoeW-1:0] doe_s2, doe_s3, doe_s4;
	logic era5_s2, era5_s3, era5_s4, era5_s5, era5_s6;
	logic [eust_pkg::WdayW-1:0] wday_s2, wday_s3, wday_s4, wday_s5, wday_s6;

	// stage 3: numerator of year of era
	logic [36:0] p1460;
	logic [7:0]  q1460;
	logic [2:0]  q36524;
	logic        q146096;
	logic [eust_pkg::DoeW-1:0] numer_s3;

	// stage 4: year of era
	logic [37:0] p365;
	logic [eust_pkg::YoeW-1:0] yoe_s4, yoe_s5, yoe_s6;

	// stage 5: day of year
	logic [eust_pkg::DoeW-1:0] yoe_days;
	logic [1:0] yoe_cent;
	logic [eust_pkg::DoyW-1:0] doy_s5, doy_s6;

	// stage 6: March-based month
	logic [10:0] mx;
	logic [22:0] mprod;
	logic [3:0]  mp_s6;

	// stage 7: civil date
	logic [eust_pkg::MonthW-1:0] mon_c;
	logic [eust_pkg::YearW-1:0]  year_c;
	logic [eust_pkg::DayW-1:0]   day_c;
	eust_pkg::civil_t            civil_s7;

	assign day_prod = 51'(unix_seconds[31:7]) * 51'(eust_pkg::DAY_RECIP);

	assign z      = 20'(days_s1) + eust_pkg::EPOCH_SHIFT;
	assign era5_c = (z >= eust_pkg::ERA5_START);
	assign wx     = days_s1 + 16'd4;
	assign wprod  = 33'(wx) * 33'(eust_pkg::W7_RECIP);
	assign wq     = wprod[32:19];

	assign p1460   = 37'(doe_s2) * 37'(eust_pkg::Q1460_RECIP);
	assign q1460   = p1460[36:29];
	assign q36524  = 3'(doe_s2 >= 18'd36524) + 3'(doe_s2 >= 18'd73048)
	               + 3'(doe_s2 >= 18'd109572) + 3'(doe_s2 >= 18'd146096);
	assign q146096 = (doe_s2 == 18'd146096);

	assign p365 = 38'(numer_s3) * 38'(eust_pkg::Q365_RECIP);

	assign yoe_cent = 2'(yoe_s4 >= 9'd100) + 2'(yoe_s4 >= 9'd200) + 2'(yoe_s4 >= 9'd300);
	assign yoe_days = 18'(yoe_s4) * 18'd365 + 18'(yoe_s4[8:2]) - 18'(yoe_cent);

	assign mx    = 11'(doy_s5) * 11'd5 + 11'd2;
	assign mprod = 23'(mx) * 23'(eust_pkg::Q153_RECIP);

	always_comb begin
		mon_c  = (mp_s6 < 4'd10) ? mp_s6 + 4'd3 : mp_s6 - 4'd9;
		day_c  = 5'(doy_s6 - eust_pkg::month_start(mp_s6) + 9'd1);
		year_c = 12'(yoe_s6) + (era5_s6 ? 12'd2000 : 12'd1600)
		       + 12'(mon_c <= 4'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s1 <= day_prod[50:35];
			t_s1    <= unix_seconds;

			doe_s2  <= 18'(z - (era5_c ? eust_pkg::ERA5_START : eust_pkg::ERA4_START));
			era5_s2 <= era5_c;
			wday_s2 <= 3'(wx - 16'(wq * 14'd7));
			t_s2    <= t_s1;

			numer_s3 <= doe_s2 - 18'(q1460) + 18'(q36524) - 18'(q146096);
			doe_s3   <= doe_s2;
			era5_s3  <= era5_s2;
			wday_s3  <= wday_s2;
			t_s3     <= t_s2;

			yoe_s4  <= p365[36:28];
			doe_s4  <= doe_s3;
			era5_s4 <= era5_s3;
			wday_s4 <= wday_s3;
			t_s4    <= t_s3;

			doy_s5  <= 9'(doe_s4 - yoe_days);
			yoe_s5  <= yoe_s4;
			era5_s5 <= era5_s4;
			wday_s5 <= wday_s4;
			t_s5    <= t_s4;

			mp_s6   <= mprod[22:19];
			doy_s6  <= doy_s5;
			yoe_s6  <= yoe_s5;
			era5_s6 <= era5_s5;
			wday_s6 <= wday_s5;
			t_s6    <= t_s5;

			civil_s7.t     <= t_s6;
			civil_s7.year  <= year_c;
			civil_s7.month <= mon_c;
			civil_s7.day   <= day_c;
			civil_s7.wday  <= wday_s6;
		end
	end

	assign out_valid = valid_s[6];
	assign civil     = civil_s7;

endmodule

// ----- rtl/core/eust_dst.sv -----
// Summer time decision, offset choice and local time sum (two stages).
`timescale 1ns / 1ps

module eust_dst (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  eust_pkg::civil_t                   civil,
	input  logic [eust_pkg::OffW-1:0]          winter_off,
	input  logic [eust_pkg::OffW-1:0]          summer_off,
	output logic                               out_valid,
	output logic                               summer_active,
	output logic signed [eust_pkg::OffW-1:0]   applied_offset,
	output logic signed [eust_pkg::LocalW-1:0] local_seconds,
	output logic [eust_pkg::YearW-1:0]         civil_year,
	output logic [eust_pkg::MonthW-1:0]        civil_month,
	output logic [eust_pkg::DayW-1:0]          civil_day
);

	logic valid_s8, valid_s9;

	logic [5:0]  wsum;
	logic [11:0] wsprod;
	logic [2:0]  wsq;
	logic [2:0]  wday31;
	logic [4:0]  last_sun;
	logic        summer_c;

	logic                        summer_s8, summer_s9;
	logic [eust_pkg::OffW-1:0]   off_s8, off_s9;
	eust_pkg::civil_t            civil_s8;
	logic [eust_pkg::LocalW-1:0] local_s9;
	eust_pkg::civil_t            civil_s9;

	// weekday of the 31st, then the last Sunday of the month
	assign wsum     = 6'(civil.wday) + 6'd31 - 6'(civil.day);
	assign wsprod   = 12'(wsum) * 12'd37;
	assign wsq      = wsprod[10:8];
	assign wday31   = 3'(wsum - 6'(wsq * 3'd7));
	assign last_sun = 5'd31 - 5'(wday31);

	always_comb begin
		case (civil.month)
			4'd3:    summer_c = (civil.day >= last_sun);
			4'd10:   summer_c = (civil.day < last_sun);
			default: summer_c = civil.month inside {[4'd4:4'd9]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s8 <= in_valid;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			summer_s8 <= summer_c;
			off_s8    <= summer_c ? summer_off : winter_off;
			civil_s8  <= civil;

			summer_s9 <= summer_s8;
			off_s9    <= off_s8;
			local_s9  <= {2'b00, civil_s8.t} + {{17{off_s8[16]}}, off_s8};
			civil_s9  <= civil_s8;
		end
	end

	assign out_valid      = valid_s9;
	assign summer_active  = summer_s9;
	assign applied_offset = off_s9;
	assign local_seconds  = local_s9;
	assign civil_year     = civil_s9.year;
	assign civil_month    = civil_s9.month;
	assign civil_day      = civil_s9.day;

endmodule

// ----- rtl/core/eu_summer_time_from_unix_seconds.sv -----
// Top level: European summer time and civil date from a UTC Unix time.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    unix_seconds
//   result    out        out_valid / out_stall  summer_active, applied_offset,
//                                               local_seconds, civil_year,
//                                               civil_month, civil_day
//   config    in         cfg_we                 cfg_index, cfg_data
//
// One item per cycle while no result is held.
// The nine pipeline stages advance together; a held result stalls all of them.
// Reset clears the stage valid bits and loads the offsets with 3600 and 7200.
// Offset registers are read at stage 8, so write them only while idle.
`timescale 1ns / 1ps

module eu_summer_time_from_unix_seconds (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [eust_pkg::TimeW-1:0]         unix_seconds,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               summer_active,
	output logic signed [eust_pkg::OffW-1:0]   applied_offset,
	output logic signed [eust_pkg::LocalW-1:0] local_seconds,
	output logic [eust_pkg::YearW-1:0]         civil_year,
	output logic [eust_pkg::MonthW-1:0]        civil_month,
	output logic [eust_pkg::DayW-1:0]          civil_day,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [eust_pkg::OffW-1:0]          cfg_data
);

	logic en;
	logic date_valid;
	eust_pkg::civil_t civil;
	logic [eust_pkg::OffW-1:0] winter_q, summer_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			winter_q <= eust_pkg::WINTER_RESET;
			summer_q <= eust_pkg::SUMMER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				eust_pkg::CFG_WINTER: winter_q <= cfg_data;
				eust_pkg::CFG_SUMMER: summer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	eust_date u_date (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.unix_seconds (unix_seconds),
		.out_valid    (date_valid),
		.civil        (civil)
	);

	eust_dst u_dst (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (date_valid),
		.civil          (civil),
		.winter_off     (winter_q),
		.summer_off     (summer_q),
		.out_valid      (out_valid),
		.summer_active  (summer_active),
		.applied_offset (applied_offset),
		.local_seconds  (local_seconds),
		.civil_year     (civil_year),
		.civil_month    (civil_month),
		.civil_day      (civil_day)
	);

endmodule

// ----- verif/eu_summer_time_from_unix_seconds_tb.sv -----
// Testbench for the summer time converter: directed calendar edges, offset extremes, random dates.
`timescale 1ns / 1ps

module eu_summer_time_from_unix_seconds_tb;

	localparam int PIPE_LATENCY = 9;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int OFF_MIN      = -43200;
	localparam int OFF_MAX      = 50400;
	localparam int MARCH        = 3;
	localparam int OCTOBER      = 10;
	localparam int RANDOM_ITEMS = 1300;

	typedef struct packed {
		logic                               summer;
		logic signed [eust_pkg::OffW-1:0]   offset;
		logic signed [eust_pkg::LocalW-1:0] local_sec;
		logic [eust_pkg::YearW-1:0]         year;
		logic [eust_pkg::MonthW-1:0]        month;
		logic [eust_pkg::DayW-1:0]          day;
	} dst_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic [eust_pkg::TimeW-1:0]         unix_seconds = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic                               summer_active;
	logic signed [eust_pkg::OffW-1:0]   applied_offset;
	logic signed [eust_pkg::LocalW-1:0] local_seconds;
	logic [eust_pkg::YearW-1:0]         civil_year;
	logic [eust_pkg::MonthW-1:0]        civil_month;
	logic [eust_pkg::DayW-1:0]          civil_day;
	logic                               cfg_we = 1'b0;
	logic                               cfg_index = eust_pkg::CFG_WINTER;
	logic [eust_pkg::OffW-1:0]          cfg_data = '0;

	// local copy of the offset registers
	logic [eust_pkg::OffW-1:0] winter_off = eust_pkg::WINTER_RESET;
	logic [eust_pkg::OffW-1:0] summer_off = eust_pkg::SUMMER_RESET;

	dst_result_t dst_queue[$];
	dst_result_t exp_res;
	int          n_fail = 0;
	int          cycle_cnt = 0;
	int          rx_hold = 0;
	bit          tx_idle_en = 1'b0;
	bit          rx_idle_en = 1'b0;

	eu_summer_time_from_unix_seconds i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.unix_seconds   (unix_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.summer_active  (summer_active),
		.applied_offset (applied_offset),
		.local_seconds  (local_seconds),
		.civil_year     (civil_year),
		.civil_month    (civil_month),
		.civil_day      (civil_day),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// mostly short idle stretches, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 96)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	// UTC seconds at a civil date and time of day (proleptic Gregorian)
	function automatic logic [eust_pkg::TimeW-1:0] utc_at(input int unsigned y,
			input int unsigned m, input int unsigned d, input int unsigned tod);
		int unsigned ya, era, yoe, mp, doy, doe;
		longint unsigned days;
		ya = y - ((m <= 2) ? 1 : 0);
		era = ya / 400;
		yoe = ya - era * 400;
		mp = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		days = longint'(era) * 146097 + doe - 719468;
		return eust_pkg::TimeW'(days * 86400 + tod);
	endfunction

	function automatic dst_result_t predict_local_time(input logic [eust_pkg::TimeW-1:0] t);
		dst_result_t r;
		int unsigned days, z, era, doe, yoe, doy, mp, mon, d, y, wd, wd31, last_sun;
		logic summer;
		logic signed [eust_pkg::OffW-1:0] off;
		days = t / 86400;
		z = days + 719468;
		era = z / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		mon = (mp < 10) ? mp + 3 : mp - 9;
		d = doy - (153 * mp + 2) / 5 + 1;
		y = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
		summer = 1'b0;
		if (mon > MARCH && mon < OCTOBER) begin
			summer = 1'b1;
		end else if (mon == MARCH || mon == OCTOBER) begin
			// weekday of the 31st, 0 is Sunday; epoch day was a Thursday
			wd = (days + 4) % 7;
			wd31 = (wd + 31 - d) % 7;
			last_sun = 31 - wd31;
			summer = (mon == MARCH) ? (d >= last_sun) : (d < last_sun);
		end
		off = summer ? summer_off : winter_off;
		r.summer = summer;
		r.offset = off;
		r.local_sec = eust_pkg::LocalW'(longint'(t) + longint'(off));
		r.year = eust_pkg::YearW'(y);
		r.month = eust_pkg::MonthW'(mon);
		r.day = eust_pkg::DayW'(d);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (dst_queue.size() == 0) begin
				$error("result transfer with no pending conversion");
				n_fail++;
			end else begin
				exp_res = dst_queue.pop_front();
				if (summer_active !== exp_res.summer) begin
					$error("summer_active: expected %0d, actual %0d", exp_res.summer, summer_active);
					n_fail++;
				end
				if (applied_offset !== exp_res.offset) begin
					$error("applied_offset: expected %0d, actual %0d",
						exp_res.offset, applied_offset);
					n_fail++;
				end
				if (local_seconds !== exp_res.local_sec) begin
					$error("local_seconds: expected %0d, actual %0d",
						exp_res.local_sec, local_seconds);
					n_fail++;
				end
				if (civil_year !== exp_res.year) begin
					$error("civil_year: expected %0d, actual %0d", exp_res.year, civil_year);
					n_fail++;
				end
				if (civil_month !== exp_res.month) begin
					$error("civil_month: expected %0d, actual %0d", exp_res.month, civil_month);
					n_fail++;
				end
				if (civil_day !== exp_res.day) begin
					$error("civil_day: expected %0d, actual %0d", exp_res.day, civil_day);
					n_fail++;
				end
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold = rx_hold - 1;
		end else begin
			out_stall <= 1'b0;
			if (rx_idle_en && $urandom_range(0, 3) == 0)
				rx_hold = pick_gap();
		end
	end

	// entered and left right after a falling edge
	task automatic send_time(input logic [eust_pkg::TimeW-1:0] t);
		int gap;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		unix_seconds <= t;
		do
			@(posedge clk);
		while (in_stall);
		dst_queue.push_back(predict_local_time(t));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (dst_queue.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 3) @(negedge clk);
	endtask

	task automatic write_offset(input logic idx, input logic [eust_pkg::OffW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == eust_pkg::CFG_WINTER)
			winter_off = val;
		else
			summer_off = val;
	endtask

	// reset offsets; epoch, last second, leap days and both switch dates
	task automatic test_calendar_edges();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_time('0);
		send_time('1);
		send_time(utc_at(1999, 12, 31, 86399));
		send_time(utc_at(2000, 2, 29, 43200));
		send_time(utc_at(2100, 3, 1, 0) - 1);
		send_time(utc_at(2100, 3, 1, 0));
		send_time(utc_at(2024, 2, 29, 3600));
		send_time(utc_at(2021, 3, 28, 0) - 1);
		send_time(utc_at(2021, 3, 28, 0));
		send_time(utc_at(2021, 10, 31, 0) - 1);
		send_time(utc_at(2021, 10, 31, 0));
		send_time(utc_at(2024, 3, 31, 0) - 1);
		send_time(utc_at(2024, 3, 31, 0));
		send_time(utc_at(2023, 10, 29, 0) - 1);
		send_time(utc_at(2023, 10, 29, 0));
		send_time(utc_at(2022, 3, 31, 86399));
		send_time(utc_at(2022, 4, 1, 0) - 1);
		send_time(utc_at(2022, 9, 30, 86399));
		send_time(utc_at(2022, 10, 1, 0));
		send_time(utc_at(2022, 11, 1, 0));
		send_time(utc_at(2022, 1, 15, 7200));
	endtask

	// range limits, then values outside that range, then -1 and 0
	task automatic test_offset_extremes();
		logic [eust_pkg::OffW-1:0] w_set[4];
		logic [eust_pkg::OffW-1:0] s_set[4];
		w_set[0] = eust_pkg::OffW'(OFF_MIN);
		s_set[0] = eust_pkg::OffW'(OFF_MAX);
		w_set[1] = eust_pkg::OffW'(OFF_MAX);
		s_set[1] = eust_pkg::OffW'(OFF_MIN);
		w_set[2] = 17'h10000;
		s_set[2] = 17'h0FFFF;
		w_set[3] = 17'h1FFFF;
		s_set[3] = 17'h00000;
		for (int i = 0; i < 4; i++) begin
			wait_drained();
			write_offset(eust_pkg::CFG_WINTER, w_set[i]);
			write_offset(eust_pkg::CFG_SUMMER, s_set[i]);
			send_time('0);
			send_time('1);
			send_time(utc_at(2021, 7, 1, 0));
			send_time(utc_at(2021, 1, 1, 0));
			send_time(utc_at(2021, 3, 28, 0));
			send_time($urandom());
		end
	endtask

	// mostly dates around the March and October switch, plus month ends and raw noise
	task automatic test_random_dates();
		int unsigned y, m, d, sel;
		logic [eust_pkg::TimeW-1:0] t;
		for (int chunk = 0; chunk < 4; chunk++) begin
			wait_drained();
			if (chunk != 0) begin
				write_offset(eust_pkg::CFG_WINTER, eust_pkg::OffW'(
					int'($urandom_range(0, OFF_MAX - OFF_MIN)) + OFF_MIN));
				write_offset(eust_pkg::CFG_SUMMER, eust_pkg::OffW'(
					int'($urandom_range(0, OFF_MAX - OFF_MIN)) + OFF_MIN));
			end
			tx_idle_en = (chunk == 1 || chunk == 3);
			rx_idle_en = (chunk == 1 || chunk == 2);
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 55) begin
					y = $urandom_range(1970, 2105);
					m = $urandom_range(0, 1) ? MARCH : OCTOBER;
					d = $urandom_range(22, 31);
					t = utc_at(y, m, d, $urandom_range(0, 86399));
				end else if (sel < 75) begin
					y = $urandom_range(1971, 2105);
					m = $urandom_range(1, 12);
					t = utc_at(y, m, 1, 0) - $urandom_range(0, 1);
				end else begin
					t = $urandom();
				end
				send_time(t);
			end
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_calendar_edges();
		test_offset_extremes();
		test_random_dates();
		wait_drained();
		if (n_fail == 0 && dst_queue.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/eust_pkg.sv
rtl/core/eust_date.sv
rtl/core/eust_dst.sv
rtl/core/eu_summer_time_from_unix_seconds.sv
verif/eu_summer_time_from_unix_seconds_tb.sv
